@@ hdl/tcf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tcf_pkg;

   typedef enum logic [3:0] {
      ST_CLOSED      = 4'd0,
      ST_LISTEN      = 4'd1,
      ST_SYN_SENT    = 4'd2,
      ST_SYN_RCVD    = 4'd3,
      ST_ESTABLISHED = 4'd4,
      ST_FIN_WAIT_1  = 4'd5,
      ST_FIN_WAIT_2  = 4'd6,
      ST_CLOSE_WAIT  = 4'd7,
      ST_LAST_ACK    = 4'd8
   } state_type;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_SEGMENT = 2'd1,
      OP_CLOSE   = 2'd2,
      OP_DATA    = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_ACTIVE_OPEN = 1'b0,
      CSR_INITIAL_SEQ = 1'b1
   } csr_index_type;

   // Received flag bit positions
   localparam int unsigned FIN_BIT = 0;
   localparam int unsigned SYN_BIT = 1;
   localparam int unsigned ACK_BIT = 4;

   // Sent flag codes
   localparam logic [7:0] FLAG_NONE = 8'd0;
   localparam logic [7:0] FLAG_FIN  = 8'd1;
   localparam logic [7:0] FLAG_SYN  = 8'd2;
   localparam logic [7:0] FLAG_ACK  = 8'd16;

   localparam logic [31:0] INITIAL_SEQ_RESET = 32'd1;

   typedef struct packed {
      logic        tx_segment;
      logic [7:0]  send_flags;
      logic [31:0] send_seq;
      logic [31:0] send_ack;
      logic        deliver_to_app;
      logic        fin_to_app;
      logic        unblock_app;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/tcp_connection_fsm_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Single-connection TCP state machine.
// Request channel (req_*): one event per item: start, network segment,
// application close or application data, with the segment flags, sequence
// and acknowledgement numbers. Every item yields exactly one result item on
// the response channel (rsp_*): the segment to send, application signals
// and the connection state after the event.
// Configuration (csr_*): index 0 selects client/server mode, index 1 sets
// the initial sequence number; csr_ready is always high. Write only while
// no item is in flight.
// An accepted item is registered in the input register, decided, and its
// result loaded into the output register, which drives rsp_valid.
// Throughput: one item per cycle while rsp_stall is low, set by the
// combinational state update between the input and output registers.
// When rsp_stall is held, the result holds and one more item is buffered in
// the input register before req_stall rises.
// Reset (synchronous, active high) empties both registers, returns the
// connection to listen, clears client mode and sets the sequence number to 1.
module tcp_connection_fsm_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [1:0]  req_operation,
   input  wire [7:0]  req_seg_flags,
   input  wire [31:0] req_seg_seq,
   input  wire [31:0] req_seg_ack,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_tx_segment,
   output logic [7:0] rsp_send_flags,
   output logic [31:0] rsp_send_seq,
   output logic [31:0] rsp_send_ack,
   output logic       rsp_deliver_to_app,
   output logic       rsp_fin_to_app,
   output logic       rsp_unblock_app,
   output logic [3:0] rsp_conn_state,
   output logic       rsp_conn_done,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [0:0]  csr_index,
   input  wire [31:0] csr_data
);

   logic                active_open_ff;
   logic [31:0]         initial_seq_ff;
   tcf_pkg::state_type  state_ff;
   tcf_pkg::state_type  state_in;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [1:0]          operation_ff;
   logic [7:0]          seg_flags_ff;
   logic [31:0]         seg_seq_ff;
   logic [31:0]         seg_ack_ff;

   logic                out_valid_ff;
   logic                out_valid_in;
   tcf_pkg::result_type result_ff;
   tcf_pkg::result_type result_in;
   tcf_pkg::state_type  out_state_ff;

   logic                advance;
   logic                req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   tcf_next u_next (
      .state       (state_ff),
      .active_open (active_open_ff),
      .initial_seq (initial_seq_ff),
      .operation   (tcf_pkg::op_type'(operation_ff)),
      .seg_flags   (seg_flags_ff),
      .seg_seq     (seg_seq_ff),
      .seg_ack     (seg_ack_ff),
      .state_next  (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         active_open_ff <= 1'b0;
         initial_seq_ff <= tcf_pkg::INITIAL_SEQ_RESET;
      end else if (csr_valid && csr_ready) begin
         case (tcf_pkg::csr_index_type'(csr_index))
            tcf_pkg::CSR_ACTIVE_OPEN: active_open_ff <= csr_data[0];
            tcf_pkg::CSR_INITIAL_SEQ: initial_seq_ff <= csr_data;
            default: begin
               active_open_ff <= active_open_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcf_pkg::ST_LISTEN;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         operation_ff <= req_operation;
         seg_flags_ff <= req_seg_flags;
         seg_seq_ff   <= req_seg_seq;
         seg_ack_ff   <= req_seg_ack;
      end
      // load the decision together with the state it leads to
      if (advance) begin
         result_ff    <= result_in;
         out_state_ff <= state_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_tx_segment     = result_ff.tx_segment;
   assign rsp_send_flags     = result_ff.send_flags;
   assign rsp_send_seq       = result_ff.send_seq;
   assign rsp_send_ack       = result_ff.send_ack;
   assign rsp_deliver_to_app = result_ff.deliver_to_app;
   assign rsp_fin_to_app     = result_ff.fin_to_app;
   assign rsp_unblock_app    = result_ff.unblock_app;
   assign rsp_conn_state     = out_state_ff;
   assign rsp_conn_done      = (out_state_ff == tcf_pkg::ST_CLOSED);

endmodule

`default_nettype wire

@@ hdl/tcf_next.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tcf_next (
   input  wire tcf_pkg::state_type  state,
   input  wire                      active_open,
   input  wire [31:0]               initial_seq,
   input  wire tcf_pkg::op_type     operation,
   input  wire [7:0]                seg_flags,
   input  wire [31:0]               seg_seq,
   input  wire [31:0]               seg_ack,
   output tcf_pkg::state_type       state_next,
   output tcf_pkg::result_type      result
);

   logic        has_fin;
   logic        has_syn;
   logic        has_ack;
   logic        ack_match;
   logic [31:0] isn_next;
   logic [31:0] peer_next;

   assign has_fin   = seg_flags[tcf_pkg::FIN_BIT];
   assign has_syn   = seg_flags[tcf_pkg::SYN_BIT];
   assign has_ack   = seg_flags[tcf_pkg::ACK_BIT];
   assign isn_next  = initial_seq + 32'd1;
   assign peer_next = seg_seq + 32'd1;
   assign ack_match = (seg_ack == isn_next);

   always_comb begin
      state_next = state;
      case (operation)
         tcf_pkg::OP_START: begin
            if (state == tcf_pkg::ST_LISTEN && active_open) begin
               state_next = tcf_pkg::ST_SYN_SENT;
            end
         end
         tcf_pkg::OP_SEGMENT: begin
            case (state)
               tcf_pkg::ST_LISTEN: begin
                  if (!active_open && has_syn) state_next = tcf_pkg::ST_SYN_RCVD;
               end
               tcf_pkg::ST_SYN_SENT: begin
                  if (has_syn && has_ack && ack_match) state_next = tcf_pkg::ST_ESTABLISHED;
               end
               tcf_pkg::ST_SYN_RCVD: begin
                  if (has_ack && ack_match) state_next = tcf_pkg::ST_ESTABLISHED;
               end
               tcf_pkg::ST_ESTABLISHED: begin
                  if (has_fin) state_next = tcf_pkg::ST_CLOSE_WAIT;
               end
               tcf_pkg::ST_FIN_WAIT_2: begin
                  if (has_fin) state_next = tcf_pkg::ST_CLOSED;
               end
               tcf_pkg::ST_FIN_WAIT_1: begin
                  if (has_ack) state_next = tcf_pkg::ST_FIN_WAIT_2;
               end
               tcf_pkg::ST_LAST_ACK: begin
                  if (has_ack) state_next = tcf_pkg::ST_CLOSED;
               end
               default: begin
                  state_next = state;
               end
            endcase
         end
         tcf_pkg::OP_CLOSE: begin
            if (state == tcf_pkg::ST_ESTABLISHED) begin
               state_next = tcf_pkg::ST_FIN_WAIT_1;
            end else if (state == tcf_pkg::ST_CLOSE_WAIT) begin
               state_next = tcf_pkg::ST_LAST_ACK;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

   always_comb begin
      result = '0;
      case (operation)
         tcf_pkg::OP_START: begin
            if (state == tcf_pkg::ST_LISTEN && active_open) begin
               result.tx_segment = 1'b1;
               result.send_flags = tcf_pkg::FLAG_SYN;
               result.send_seq   = initial_seq;
            end
         end
         tcf_pkg::OP_SEGMENT: begin
            case (state)
               tcf_pkg::ST_LISTEN: begin
                  if (!active_open && has_syn) begin
                     result.tx_segment = 1'b1;
                     result.send_flags = tcf_pkg::FLAG_SYN | tcf_pkg::FLAG_ACK;
                     result.send_seq   = initial_seq;
                     result.send_ack   = peer_next;
                  end
               end
               tcf_pkg::ST_SYN_SENT: begin
                  if (has_syn && has_ack && ack_match) begin
                     result.tx_segment  = 1'b1;
                     result.send_flags  = tcf_pkg::FLAG_ACK;
                     result.send_ack    = peer_next;
                     result.unblock_app = 1'b1;
                  end
               end
               tcf_pkg::ST_SYN_RCVD: begin
                  result.unblock_app = has_ack && ack_match;
               end
               tcf_pkg::ST_ESTABLISHED,
               tcf_pkg::ST_FIN_WAIT_2: begin
                  if (has_fin) begin
                     result.tx_segment = 1'b1;
                     result.send_flags = tcf_pkg::FLAG_ACK;
                     result.fin_to_app = 1'b1;
                  end else begin
                     result.deliver_to_app = 1'b1;
                  end
               end
               tcf_pkg::ST_FIN_WAIT_1,
               tcf_pkg::ST_LAST_ACK: begin
                  result.deliver_to_app = !has_ack;
               end
               tcf_pkg::ST_CLOSE_WAIT: begin
                  result.deliver_to_app = 1'b1;
               end
               default: begin
                  result = '0;
               end
            endcase
         end
         tcf_pkg::OP_CLOSE: begin
            if (state == tcf_pkg::ST_ESTABLISHED || state == tcf_pkg::ST_CLOSE_WAIT) begin
               result.tx_segment = 1'b1;
               result.send_flags = tcf_pkg::FLAG_FIN;
            end
         end
         tcf_pkg::OP_DATA: begin
            if (state == tcf_pkg::ST_ESTABLISHED || state == tcf_pkg::ST_FIN_WAIT_1 ||
                state == tcf_pkg::ST_FIN_WAIT_2 || state == tcf_pkg::ST_CLOSE_WAIT ||
                state == tcf_pkg::ST_LAST_ACK) begin
               result.tx_segment = 1'b1;
               result.send_flags = tcf_pkg::FLAG_NONE;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

`default_nettype wire
